@@ rtl/ccdc_pkg.sv @@
// Shared types, constants and codes for the character cell depth compositor.
`timescale 1ns / 1ps

package ccdc_pkg;

    // Frame store geometry
    localparam int MAX_COLS  = 128;
    localparam int MAX_ROWS  = 64;
    localparam int MEM_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int IDX_W     = $clog2(MEM_DEPTH);
    localparam int COL_W     = $clog2(MAX_COLS + 1);
    localparam int ROW_W     = $clog2(MAX_ROWS + 1);
    localparam int COL_IDX_W = $clog2(MAX_COLS);
    localparam int ROW_IDX_W = $clog2(MAX_ROWS);
    localparam int CELLS_W   = COL_W + ROW_W;

    // Field widths
    localparam int POS_W   = 12;
    localparam int DEPTH_W = 16;
    localparam int CELL_W  = 16;
    localparam int MEM_W   = CELL_W + DEPTH_W;

    // Configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CLEAR_COLOR   = 2'd2;

    localparam logic [7:0] RST_SCREEN_WIDTH  = 8'd80;
    localparam logic [6:0] RST_SCREEN_HEIGHT = 7'd25;
    localparam logic [3:0] RST_CLEAR_COLOR   = 4'd0;

    // Command codes
    localparam logic [1:0] FUNC_CLEAR     = 2'd0;
    localparam logic [1:0] FUNC_DRAW      = 2'd1;
    localparam logic [1:0] FUNC_DRAW_CLIP = 2'd2;
    localparam logic [1:0] FUNC_READ      = 2'd3;

    localparam logic [1:0] KIND_TEXT   = 2'd0;
    localparam logic [1:0] KIND_OPAQUE = 2'd1;
    localparam logic [1:0] KIND_TRANSP = 2'd2;

    localparam logic [7:0]         GLYPH_SPACE = 8'h20;
    localparam logic [DEPTH_W-1:0] DEPTH_EMPTY = '1;

    typedef struct packed {
        logic [1:0]                func;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic [7:0]                glyph;
        logic [3:0]                fg_color;
        logic [4:0]                bg_color;
        logic [1:0]                cell_kind;
        logic signed [DEPTH_W-1:0] depth;
        logic signed [POS_W-1:0]   clip_left;
        logic signed [POS_W-1:0]   clip_top;
        logic signed [POS_W-1:0]   clip_right;
        logic signed [POS_W-1:0]   clip_bottom;
    } cmd_t;

    typedef struct packed {
        logic [7:0]                cell_glyph;
        logic [7:0]                cell_attr;
        logic signed [DEPTH_W-1:0] cell_depth;
        logic                      drawn;
    } res_t;

    typedef struct packed {
        logic [7:0] screen_width;
        logic [6:0] screen_height;
        logic [3:0] clear_color;
    } cfg_t;

    // Address decode of one command
    typedef struct packed {
        logic             on;
        logic             visible;
        logic [IDX_W-1:0] idx;
        logic             fill_none;
        logic [IDX_W-1:0] fill_last;
    } dec_t;

    // Frame store port
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [MEM_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHECK,
        ST_FILL
    } state_t;

endpackage

@@ rtl/ccdc_store.sv @@
// Frame store RAM: glyph, attribute and depth per cell, registered read.
`timescale 1ns / 1ps

module ccdc_store (
    input  logic                   clk,
    input  ccdc_pkg::mem_req_t     req,
    output logic [ccdc_pkg::MEM_W-1:0] rdata
);
    import ccdc_pkg::*;

    logic [MEM_W-1:0] store_mem [MEM_DEPTH];
    logic [MEM_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            store_mem[req.waddr] <= req.wdata;
        end
    end

    // Read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= store_mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ccdc_regs.sv @@
// APB configuration registers: screen size and clear color.
`timescale 1ns / 1ps

module ccdc_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ccdc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [ccdc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [ccdc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    output ccdc_pkg::cfg_t                   cfg
);
    import ccdc_pkg::*;

    logic [7:0] screen_width_reg;
    logic [6:0] screen_height_reg;
    logic [3:0] clear_color_reg;

    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[REG_IDX_W+1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= RST_SCREEN_WIDTH;
            screen_height_reg <= RST_SCREEN_HEIGHT;
            clear_color_reg   <= RST_CLEAR_COLOR;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SCREEN_WIDTH:  screen_width_reg  <= pwdata[7:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= pwdata[6:0];
                REG_CLEAR_COLOR:   clear_color_reg   <= pwdata[3:0];
                default:           ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_SCREEN_WIDTH:  prdata = CFG_DATA_W'(screen_width_reg);
            REG_SCREEN_HEIGHT: prdata = CFG_DATA_W'(screen_height_reg);
            REG_CLEAR_COLOR:   prdata = CFG_DATA_W'(clear_color_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.screen_width  = screen_width_reg;
    assign cfg.screen_height = screen_height_reg;
    assign cfg.clear_color   = clear_color_reg;

endmodule

@@ rtl/ccdc_decode.sv @@
// Command decode: screen and clip test, cell address, clear extent.
`timescale 1ns / 1ps

module ccdc_decode (
    input  ccdc_pkg::cmd_t cmd,
    input  ccdc_pkg::cfg_t cfg,
    output ccdc_pkg::dec_t dec
);
    import ccdc_pkg::*;

    logic [COL_W-1:0]             w_use;
    logic [ROW_W-1:0]             h_use;
    logic                         on_x;
    logic                         on_y;
    logic                         in_clip;
    logic [ROW_IDX_W+COL_W-1:0]   row_base;
    logic [CELLS_W-1:0]           cells;

    // Saturate the screen size to the store geometry
    always_comb
    begin
        if (int'(cfg.screen_width) > MAX_COLS)
            w_use = COL_W'(MAX_COLS);
        else
            w_use = COL_W'(cfg.screen_width);
        if (int'(cfg.screen_height) > MAX_ROWS)
            h_use = ROW_W'(MAX_ROWS);
        else
            h_use = ROW_W'(cfg.screen_height);
    end

    // On-screen test; a negative coordinate has its sign bit set
    assign on_x = !cmd.pos_x[POS_W-1] && (POS_W'(w_use) > $unsigned(cmd.pos_x));
    assign on_y = !cmd.pos_y[POS_W-1] && (POS_W'(h_use) > $unsigned(cmd.pos_y));

    // Inclusive clip rectangle
    assign in_clip = ($signed(cmd.pos_x) >= $signed(cmd.clip_left))  &&
                     ($signed(cmd.pos_x) <= $signed(cmd.clip_right)) &&
                     ($signed(cmd.pos_y) >= $signed(cmd.clip_top))   &&
                     ($signed(cmd.pos_y) <= $signed(cmd.clip_bottom));

    // Row-major address with stride equal to the columns in use
    assign row_base = (ROW_IDX_W+COL_W)'(cmd.pos_y[ROW_IDX_W-1:0]) *
                      (ROW_IDX_W+COL_W)'(w_use);
    assign cells    = CELLS_W'(w_use) * CELLS_W'(h_use);

    assign dec.on        = on_x && on_y;
    assign dec.visible   = on_x && on_y && ((cmd.func != FUNC_DRAW_CLIP) || in_clip);
    assign dec.idx       = IDX_W'(row_base) + IDX_W'(cmd.pos_x[COL_IDX_W-1:0]);
    assign dec.fill_none = (cells == '0);
    assign dec.fill_last = IDX_W'(cells - CELLS_W'(1));

endmodule

@@ rtl/ccdc_ctrl.sv @@
// Sequencer: store init sweep, clear fill, read-compare-write of one cell, result.
`timescale 1ns / 1ps

module ccdc_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  ccdc_pkg::cmd_t              cmd,
    input  ccdc_pkg::dec_t              dec,
    input  ccdc_pkg::cfg_t              cfg,
    input  logic [ccdc_pkg::MEM_W-1:0]  rdata,
    output ccdc_pkg::mem_req_t          mem_req,
    output logic                        busy,
    output logic                        done,
    output ccdc_pkg::res_t              result
);
    import ccdc_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] fill_idx_reg, fill_idx_next;
    logic             done_reg, done_next;
    cmd_t             item_reg, item_next;
    dec_t             dec_reg, dec_next;
    res_t             result_reg, result_next;

    logic [CELL_W-1:0]  rd_cell;
    logic [DEPTH_W-1:0] rd_depth;
    logic               write_ok;
    logic [7:0]         new_glyph;
    logic [7:0]         new_attr;
    logic [CELL_W-1:0]  blank_cell;
    logic [CELL_W-1:0]  init_cell;

    assign rd_cell  = rdata[CELL_W-1:0];
    assign rd_depth = rdata[MEM_W-1:CELL_W];

    assign blank_cell = {cfg.clear_color, 4'h0, GLYPH_SPACE};
    assign init_cell  = {RST_CLEAR_COLOR, 4'h0, GLYPH_SPACE};

    // Depth test and new cell contents for a draw
    always_comb
    begin
        write_ok = ((item_reg.func == FUNC_DRAW) || (item_reg.func == FUNC_DRAW_CLIP)) &&
                   dec_reg.visible &&
                   ((item_reg.cell_kind == KIND_TEXT) || (item_reg.cell_kind == KIND_OPAQUE)) &&
                   ($signed(rd_depth) <= $signed(item_reg.depth));
        if (item_reg.cell_kind == KIND_TEXT)
        begin
            new_glyph = item_reg.glyph;
            new_attr  = {(item_reg.bg_color[4] ? 4'h0 : item_reg.bg_color[3:0]),
                         item_reg.fg_color};
        end
        else
        begin
            new_glyph = GLYPH_SPACE;
            new_attr  = {item_reg.bg_color[3:0], 4'h0};
        end
    end

    // State and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            fill_idx_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_idx_reg <= fill_idx_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        dec_reg    <= dec_next;
        result_reg <= result_next;
    end

    // Next state, store port and result
    always_comb
    begin
        state_next    = state_reg;
        fill_idx_next = fill_idx_reg;
        done_next     = 1'b0;
        item_next     = item_reg;
        dec_next      = dec_reg;
        result_next   = result_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = fill_idx_reg;
        mem_req.wdata = {DEPTH_EMPTY, blank_cell};
        mem_req.raddr = dec.idx;

        unique case (state_reg)
            ST_INIT:
            begin
                // Sweep every entry to the reset contents
                mem_req.we    = 1'b1;
                mem_req.wdata = {DEPTH_EMPTY, init_cell};
                fill_idx_next = fill_idx_reg + IDX_W'(1);
                if (fill_idx_reg == IDX_W'(MEM_DEPTH - 1))
                    state_next = ST_IDLE;
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    item_next     = cmd;
                    dec_next      = dec;
                    fill_idx_next = '0;
                    if (cmd.func == FUNC_CLEAR)
                        state_next = ST_FILL;
                    else
                        state_next = ST_CHECK;
                end
            end

            ST_FILL:
            begin
                // One cell per cycle over the cells in use
                mem_req.we    = !dec_reg.fill_none;
                fill_idx_next = fill_idx_reg + IDX_W'(1);
                if (dec_reg.fill_none || (fill_idx_reg == dec_reg.fill_last))
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    if (dec_reg.on)
                    begin
                        result_next.cell_glyph = blank_cell[7:0];
                        result_next.cell_attr  = blank_cell[15:8];
                        result_next.cell_depth = DEPTH_EMPTY;
                    end
                    else
                    begin
                        result_next.cell_glyph = '0;
                        result_next.cell_attr  = '0;
                        result_next.cell_depth = '0;
                    end
                    result_next.drawn = 1'b0;
                end
            end

            ST_CHECK:
            begin
                // Stored cell is on rdata: compare, write back, report
                mem_req.we    = write_ok;
                mem_req.waddr = dec_reg.idx;
                mem_req.wdata = {item_reg.depth, new_attr, new_glyph};
                state_next    = ST_IDLE;
                done_next     = 1'b1;
                if (!dec_reg.on)
                begin
                    result_next.cell_glyph = '0;
                    result_next.cell_attr  = '0;
                    result_next.cell_depth = '0;
                end
                else if (write_ok)
                begin
                    result_next.cell_glyph = new_glyph;
                    result_next.cell_attr  = new_attr;
                    result_next.cell_depth = item_reg.depth;
                end
                else
                begin
                    result_next.cell_glyph = rd_cell[7:0];
                    result_next.cell_attr  = rd_cell[15:8];
                    result_next.cell_depth = rd_depth;
                end
                result_next.drawn = write_ok;
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ rtl/char_cell_depth_compositor.sv @@
// Top level of the character cell depth compositor.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low; its one result beat
// appears on result with done high for exactly one cycle and must be taken
// then, as the block cannot be held off. Draw and read commands go through
// the frame store read, then the depth compare and write back, before the
// next command can be accepted. A clear fills the w*h cells in use (w, h the
// screen size saturated to 128 x 64) through the single store write port,
// one cell per cycle. After reset, busy stays high while the whole store is
// swept to blank cells at depth -1; configuration writes are accepted during
// that time.
module char_cell_depth_compositor (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  ccdc_pkg::cmd_t                   cmd,
    output logic                             busy,
    output logic                             done,
    output ccdc_pkg::res_t                   result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ccdc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [ccdc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [ccdc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import ccdc_pkg::*;

    cfg_t             cfg;
    dec_t             dec;
    mem_req_t         mem_req;
    logic [MEM_W-1:0] rdata;

    ccdc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ccdc_decode u_decode (
        .cmd (cmd),
        .cfg (cfg),
        .dec (dec)
    );

    ccdc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .dec     (dec),
        .cfg     (cfg),
        .rdata   (rdata),
        .mem_req (mem_req),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    ccdc_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

endmodule

@@ rtl/ccdc_check.sv @@
// Port-level checks on the command handshake and result beat, bound to the top level.
`timescale 1ns / 1ps

module ccdc_check (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // Result beats are single-cycle and never back to back
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat held for more than one cycle");

    // The block is idle again when its result shows
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while still busy");

    // An accepted command always occupies the block
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted without going busy");

    // No result in the cycle right after an accept
    a_accept_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result beat one cycle after accept");

endmodule

bind char_cell_depth_compositor ccdc_check u_check (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
